// ===== hdl/bot_pkg.sv =====
// Shared constants for the box overlap tagger.
`default_nettype none
package bot_pkg;

  localparam int unsigned MAX_TRUTH_DEF  = 16;
  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned OP_BITS  = 2;
  localparam int unsigned TAG_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD      = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLASSIFY = 2'd2;

  localparam logic [TAG_BITS-1:0] TAG_OBJECT    = 2'd0;
  localparam logic [TAG_BITS-1:0] TAG_PERSON    = 2'd1;
  localparam logic [TAG_BITS-1:0] TAG_UNDEFINED = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/box_overlap_tagger_unit.sv =====
// Box overlap tagger: ground-truth box table and overlap classification walk.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+--------------------------
//  command | operation, box_x, box_y, box_w, box_h     | start && !busy
//  result  | tag                                       | done, one cycle, no stall
//
// Busy stays low for add and clear.
// A classify of an empty table returns object in the cycle after acceptance.
// A classify over N stored boxes reads one table entry per cycle through the
// score pipeline; the walk ends after the last entry or at the first person
// match, and busy falls with done.
// rst is synchronous and empties the table; stored box words are not cleared.
`default_nettype none
module box_overlap_tagger_unit #(
  parameter int unsigned MAX_TRUTH  = bot_pkg::MAX_TRUTH_DEF,
  parameter int unsigned COORD_BITS = bot_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bot_pkg::OP_BITS-1:0]   operation,
  input  wire logic [COORD_BITS-1:0]         box_x,
  input  wire logic [COORD_BITS-1:0]         box_y,
  input  wire logic [COORD_BITS-1:0]         box_w,
  input  wire logic [COORD_BITS-1:0]         box_h,
  output logic                               done,
  output logic [bot_pkg::TAG_BITS-1:0]       tag
);

  localparam int unsigned AW = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int unsigned CW = $clog2(MAX_TRUTH + 1);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned S  = COORD_BITS + 1;
  localparam int unsigned PW = 2 * S + 4;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  typedef logic [4*C-1:0] box_word_t;

  logic [4*C-1:0] mem [MAX_TRUTH];
  box_word_t      mem_q;

  logic          st;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [C-1:0]  p_x, p_y, p_w, p_h;

  logic          accept;
  logic          issue;
  logic          issue_last;

  logic          s1_vld, s1_last;
  logic          s2_vld, s2_last, s2_hit;
  logic [S-1:0]  s2_iw, s2_ih, s2_bw, s2_bh;
  logic          s3_vld, s3_last, s3_hit;
  logic [2*S-1:0] s3_inter, s3_bound;

  logic [C-1:0]  g_x, g_y, g_w, g_h;
  logic [S-1:0]  px1, py1, px2, py2, gx1, gy1, gx2, gy2;
  logic [S-1:0]  ix1, iy1, ix2, iy2, bx1, by1, bx2, by2;
  logic          hit;

  logic [PW-1:0] inter_w, bound_w, inter5, bound3, inter10;
  logic [bot_pkg::TAG_BITS-1:0] score;
  logic          finish;

  assign accept     = start && !busy;
  assign busy       = (st == ST_WALK);
  assign issue      = (st == ST_WALK) && (rd_idx < count);
  assign issue_last = (rd_idx == count - CW'(1));

  // table write on add
  always_ff @(posedge clk) begin
    if (accept && operation == bot_pkg::OP_ADD && count < CW'(MAX_TRUTH)) begin
      mem[count[AW-1:0]] <= {box_x, box_y, box_w, box_h};
    end
  end

  // table read, one entry per cycle during the walk
  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // stage 1: edges of intersection and bounding rectangle
  assign {g_x, g_y, g_w, g_h} = mem_q;
  assign px1 = S'(p_x);
  assign py1 = S'(p_y);
  assign px2 = S'(p_x) + S'(p_w);
  assign py2 = S'(p_y) + S'(p_h);
  assign gx1 = S'(g_x);
  assign gy1 = S'(g_y);
  assign gx2 = S'(g_x) + S'(g_w);
  assign gy2 = S'(g_y) + S'(g_h);
  assign ix1 = (px1 > gx1) ? px1 : gx1;
  assign iy1 = (py1 > gy1) ? py1 : gy1;
  assign ix2 = (px2 < gx2) ? px2 : gx2;
  assign iy2 = (py2 < gy2) ? py2 : gy2;
  assign bx1 = (px1 < gx1) ? px1 : gx1;
  assign by1 = (py1 < gy1) ? py1 : gy1;
  assign bx2 = (px2 > gx2) ? px2 : gx2;
  assign by2 = (py2 > gy2) ? py2 : gy2;
  assign hit = (ix2 > ix1) && (iy2 > iy1);

  always_ff @(posedge clk) begin
    s2_hit  <= hit;
    s2_last <= s1_last;
    s2_iw   <= ix2 - ix1;
    s2_ih   <= iy2 - iy1;
    s2_bw   <= bx2 - bx1;
    s2_bh   <= by2 - by1;
  end

  // stage 2: areas
  always_ff @(posedge clk) begin
    s3_hit   <= s2_hit;
    s3_last  <= s2_last;
    s3_inter <= s2_iw * s2_ih;
    s3_bound <= s2_bw * s2_bh;
  end

  // stage 3: thresholds 0.6 and 0.1
  assign inter_w = PW'(s3_inter);
  assign bound_w = PW'(s3_bound);
  assign inter5  = (inter_w << 2) + inter_w;
  assign bound3  = (bound_w << 1) + bound_w;
  assign inter10 = inter5 << 1;

  always_comb begin
    priority if (!s3_hit) begin
      score = bot_pkg::TAG_OBJECT;
    end else if (inter5 >= bound3) begin
      score = bot_pkg::TAG_PERSON;
    end else if (inter10 > bound_w) begin
      score = bot_pkg::TAG_UNDEFINED;
    end else begin
      score = bot_pkg::TAG_OBJECT;
    end
  end

  assign finish = s3_vld && (s3_last || score == bot_pkg::TAG_PERSON);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      count  <= '0;
      rd_idx <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      done   <= 1'b0;
      tag    <= bot_pkg::TAG_OBJECT;
    end else begin
      done <= 1'b0;
      if (st == ST_WALK) begin
        if (finish) begin
          st     <= ST_IDLE;
          s1_vld <= 1'b0;
          s2_vld <= 1'b0;
          s3_vld <= 1'b0;
          done   <= 1'b1;
          tag    <= score;
        end else begin
          s1_vld <= issue;
          s2_vld <= s1_vld;
          s3_vld <= s2_vld;
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
        end
      end else if (accept) begin
        unique case (operation)
          bot_pkg::OP_CLEAR: begin
            count <= '0;
          end
          bot_pkg::OP_ADD: begin
            if (count < CW'(MAX_TRUTH)) begin
              count <= count + CW'(1);
            end
          end
          bot_pkg::OP_CLASSIFY: begin
            if (count == '0) begin
              done <= 1'b1;
              tag  <= bot_pkg::TAG_OBJECT;
            end else begin
              st     <= ST_WALK;
              rd_idx <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pipeline tags and predicted box
  always_ff @(posedge clk) begin
    s1_last <= issue_last;
    if (accept) begin
      p_x <= box_x;
      p_y <= box_y;
      p_w <= box_w;
      p_h <= box_h;
    end
  end

endmodule
`default_nettype wire
